/* rtl/core/k_least_select_with_positions_defines.svh */
// Assertion macros for the k-least selector.
// Used by k_least_select_with_positions.sv; no other dependencies.
`ifndef K_LEAST_SELECT_WITH_POSITIONS_DEFINES_SVH
`define K_LEAST_SELECT_WITH_POSITIONS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KLS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/klsel_pkg.sv */
// Package for the k-least selector: sizes, register reset, request codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps

package klsel_pkg;

    localparam int K_MAX_DEFAULT      = 16;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam int CFG_K_W = 5;
    localparam int COUNT_W = 32;
    localparam int POS_W   = 32;
    localparam int FIELD_W = 32;

    localparam logic [CFG_K_W-1:0] K_IN_USE_RESET = 5'd16;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_ADD_RES,
        ST_READ_ADDR,
        ST_READ_OUT
    } state_t;

endpackage

/* rtl/core/k_least_select_with_positions.sv */
// Streaming k-smallest selector with arrival positions, top level.
// Depends on klsel_pkg and k_least_select_with_positions_defines.svh.
`timescale 1ns / 1ps
`include "k_least_select_with_positions_defines.svh"

// Keeps the k smallest signed keys of a stream (k = k_in_use clamped to
// 1..K_MAX) together with the arrival position of each. An add transfer
// (req_type 0) returns one result carrying the saturating add count. A read
// transfer (req_type 1) returns k results, one per slot in slot order,
// unsorted; slot_filled is low for slots not yet written, and last_of_run
// marks the final result. Slots live in one single-port-read memory, and
// one signed comparator is shared by the max search and the replace test.
// Timing: the block takes one transfer at a time (in_ready high only when
// idle). An add while slots are still free goes through accept, write and
// result. An add once full reads the k slots through the comparator, drains
// the registered read, compares and writes, and gives the result. A read
// alternates an address state and an output state for each slot, set by the
// registered memory read. Output stalls lengthen these steps; a waiting
// result sits in the output register, so the next transfer is accepted
// meanwhile. No clearing pass runs after reset. The user writes k_in_use
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
module k_least_select_with_positions #(
    parameter int K_MAX      = klsel_pkg::K_MAX_DEFAULT,
    parameter int VALUE_BITS = klsel_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration
    input  logic                                cfg_wr_en,
    input  logic [klsel_pkg::CFG_K_W-1:0]       cfg_wr_data,

    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic signed [klsel_pkg::FIELD_W-1:0] sample_value,

    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [klsel_pkg::COUNT_W-1:0]       item_count,
    output logic signed [klsel_pkg::FIELD_W-1:0] kept_value,
    output logic [klsel_pkg::POS_W-1:0]         kept_position,
    output logic                                slot_filled,
    output logic                                last_of_run
);

    localparam int CNT_W   = $clog2(K_MAX + 1);
    localparam int IDX_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int POS_W   = klsel_pkg::POS_W;
    localparam int COUNT_W = klsel_pkg::COUNT_W;
    localparam int FIELD_W = klsel_pkg::FIELD_W;
    localparam int ENTRY_W = VALUE_BITS + POS_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    klsel_pkg::state_t state_reg, state_next;

    logic [klsel_pkg::CFG_K_W-1:0] k_in_use_reg;
    logic [CNT_W-1:0]              filled_count_reg, filled_count_next;
    logic [COUNT_W-1:0]            arrival_counter_reg, arrival_counter_next;

    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [VALUE_BITS-1:0]         sample_reg, sample_next;
    logic [POS_W-1:0]              pos_reg, pos_next;

    // scan pipeline: data_vld_reg marks that rd_data_reg holds slot data_idx_reg
    logic                          data_vld_reg, data_vld_next;
    logic [IDX_W-1:0]              data_idx_reg, data_idx_next;
    logic [VALUE_BITS-1:0]         max_val_reg, max_val_next;
    logic [IDX_W-1:0]              max_idx_reg, max_idx_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]            item_count_reg, item_count_next;
    logic [FIELD_W-1:0]            kept_value_reg, kept_value_next;
    logic [POS_W-1:0]              kept_position_reg, kept_position_next;
    logic                          slot_filled_reg, slot_filled_next;
    logic                          last_of_run_reg, last_of_run_next;

    // slot memory: {position, value}
    logic [ENTRY_W-1:0]            slot_mem [K_MAX];
    logic [ENTRY_W-1:0]            rd_data_reg;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [ENTRY_W-1:0]            mem_wdata;

    // ------------------------------------------------------------------
    // Derived control
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]      k_act;
    logic                  accept;
    logic                  out_free;
    logic                  idx_last;
    logic                  idx_filled;
    logic [VALUE_BITS-1:0] rd_val;
    logic [POS_W-1:0]      rd_pos;
    logic [VALUE_BITS-1:0] cmp_a, cmp_b;
    logic                  cmp_gt;

    // effective k: zero acts as one, anything above capacity as K_MAX
    always_comb
    begin
        if (k_in_use_reg == '0)
        begin
            k_act = CNT_W'(1);
        end
        else if (int'(k_in_use_reg) > K_MAX)
        begin
            k_act = CNT_W'(K_MAX);
        end
        else
        begin
            k_act = CNT_W'(k_in_use_reg);
        end
    end

    assign in_ready   = (state_reg == klsel_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign idx_last   = (CNT_W'(idx_reg) == (k_act - CNT_W'(1)));
    assign idx_filled = (CNT_W'(idx_reg) < filled_count_reg);

    assign rd_val = rd_data_reg[VALUE_BITS-1:0];
    assign rd_pos = rd_data_reg[ENTRY_W-1:VALUE_BITS];

    // shared signed comparator: max search during the scan,
    // "current max > new sample" in the decide cycle
    assign cmp_a  = (state_reg == klsel_pkg::ST_DECIDE) ? max_val_reg : rd_val;
    assign cmp_b  = (state_reg == klsel_pkg::ST_DECIDE) ? sample_reg : max_val_reg;
    assign cmp_gt = ($signed(cmp_a) > $signed(cmp_b));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            klsel_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == klsel_pkg::REQ_READ)
                    begin
                        state_next = klsel_pkg::ST_READ_ADDR;
                    end
                    else if (filled_count_reg < k_act)
                    begin
                        state_next = klsel_pkg::ST_FILL;
                    end
                    else
                    begin
                        state_next = klsel_pkg::ST_SCAN;
                    end
                end
            end
            klsel_pkg::ST_FILL:
            begin
                state_next = klsel_pkg::ST_ADD_RES;
            end
            klsel_pkg::ST_SCAN:
            begin
                if (idx_last)
                begin
                    state_next = klsel_pkg::ST_DRAIN;
                end
            end
            klsel_pkg::ST_DRAIN:
            begin
                state_next = klsel_pkg::ST_DECIDE;
            end
            klsel_pkg::ST_DECIDE:
            begin
                state_next = klsel_pkg::ST_ADD_RES;
            end
            klsel_pkg::ST_ADD_RES:
            begin
                if (out_free)
                begin
                    state_next = klsel_pkg::ST_IDLE;
                end
            end
            klsel_pkg::ST_READ_ADDR:
            begin
                state_next = klsel_pkg::ST_READ_OUT;
            end
            klsel_pkg::ST_READ_OUT:
            begin
                if (out_free)
                begin
                    state_next = idx_last ? klsel_pkg::ST_IDLE : klsel_pkg::ST_READ_ADDR;
                end
            end
            default:
            begin
                state_next = klsel_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        filled_count_next    = filled_count_reg;
        arrival_counter_next = arrival_counter_reg;
        idx_next             = idx_reg;
        sample_next          = sample_reg;
        pos_next             = pos_reg;
        data_vld_next        = 1'b0;
        data_idx_next        = idx_reg;
        max_val_next         = max_val_reg;
        max_idx_next         = max_idx_reg;
        mem_we               = 1'b0;
        mem_waddr            = max_idx_reg;
        mem_wdata            = {pos_reg, sample_reg};

        out_valid_next       = out_valid_reg && !out_ready;
        item_count_next      = item_count_reg;
        kept_value_next      = kept_value_reg;
        kept_position_next   = kept_position_reg;
        slot_filled_next     = slot_filled_reg;
        last_of_run_next     = last_of_run_reg;

        // comparator consumes the slot read issued in the previous cycle
        if (data_vld_reg && ((data_idx_reg == '0) || cmp_gt))
        begin
            max_val_next = rd_val;
            max_idx_next = data_idx_reg;
        end

        unique case (state_reg)
            klsel_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next    = '0;
                    sample_next = VALUE_BITS'(sample_value);
                    pos_next    = arrival_counter_reg;
                    if ((req_type == klsel_pkg::REQ_ADD) && (arrival_counter_reg != '1))
                    begin
                        arrival_counter_next = arrival_counter_reg + COUNT_W'(1);
                    end
                end
            end
            klsel_pkg::ST_FILL:
            begin
                mem_we            = 1'b1;
                mem_waddr         = filled_count_reg[IDX_W-1:0];
                filled_count_next = filled_count_reg + CNT_W'(1);
            end
            klsel_pkg::ST_SCAN:
            begin
                data_vld_next = 1'b1;
                data_idx_next = idx_reg;
                if (!idx_last)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            klsel_pkg::ST_DRAIN:
            begin
                // last slot is compared here
            end
            klsel_pkg::ST_DECIDE:
            begin
                // strictly smaller than the current max replaces it
                mem_we = cmp_gt;
            end
            klsel_pkg::ST_ADD_RES:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    item_count_next    = arrival_counter_reg;
                    kept_value_next    = '0;
                    kept_position_next = '0;
                    slot_filled_next   = 1'b0;
                    last_of_run_next   = 1'b1;
                end
            end
            klsel_pkg::ST_READ_ADDR:
            begin
                // memory read of slot idx_reg in flight
            end
            klsel_pkg::ST_READ_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    item_count_next    = arrival_counter_reg;
                    kept_value_next    = idx_filled ? FIELD_W'(rd_val) : '0;
                    kept_position_next = idx_filled ? rd_pos : '0;
                    slot_filled_next   = idx_filled;
                    last_of_run_next   = idx_last;
                    if (!idx_last)
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= klsel_pkg::ST_IDLE;
            k_in_use_reg        <= klsel_pkg::K_IN_USE_RESET;
            filled_count_reg    <= '0;
            arrival_counter_reg <= '0;
            data_vld_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            filled_count_reg    <= filled_count_next;
            arrival_counter_reg <= arrival_counter_next;
            data_vld_reg        <= data_vld_next;
            out_valid_reg       <= out_valid_next;
            if (cfg_wr_en)
            begin
                k_in_use_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg           <= idx_next;
        sample_reg        <= sample_next;
        pos_reg           <= pos_next;
        data_idx_reg      <= data_idx_next;
        max_val_reg       <= max_val_next;
        max_idx_reg       <= max_idx_next;
        item_count_reg    <= item_count_next;
        kept_value_reg    <= kept_value_next;
        kept_position_reg <= kept_position_next;
        slot_filled_reg   <= slot_filled_next;
        last_of_run_reg   <= last_of_run_next;
    end

    // slot memory, one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[idx_reg];
    end

    assign out_valid     = out_valid_reg;
    assign item_count    = item_count_reg;
    assign kept_value    = kept_value_reg;
    assign kept_position = kept_position_reg;
    assign slot_filled   = slot_filled_reg;
    assign last_of_run   = last_of_run_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `KLS_ASSERT_IMPL(a_filled_bound, clk, rst_n, 1'b1, filled_count_reg <= CNT_W'(K_MAX), "filled count above capacity")
    `KLS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_ready, "ready right after a transfer")
    `KLS_ASSERT_NEXT(a_count_monotonic, clk, rst_n, 1'b1, arrival_counter_reg >= $past(arrival_counter_reg), "arrival counter went down")
    `KLS_ASSERT_IMPL(a_write_in_range, clk, rst_n, mem_we, CNT_W'(mem_waddr) < k_act, "slot write beyond k")

endmodule
